/* src/rtp_pkg.sv */
// Shared types, constants and sequencer states of the task picker.
package rtp_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int NUM_INSTANCES = 64;
   localparam int NUM_MODELS    = 32;
   localparam int CLEANUP_DEPTH = 32;

   localparam int QIW = $clog2(QUEUE_DEPTH);        // queue slot index
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);    // queue fill count
   localparam int CIW = $clog2(CLEANUP_DEPTH);      // cleanup fifo pointer
   localparam int CCW = $clog2(CLEANUP_DEPTH + 1);  // cleanup fifo fill count
   localparam int CNTW = 8;
   localparam logic [CNTW-1:0] COUNT_MAX = '1;

   localparam int INSTW  = 6;
   localparam int MODELW = 5;
   localparam int TAGW   = 8;
   localparam int THRW   = 7;
   localparam logic [THRW-1:0] THREAD_RESET = 7'd4;

   // command codes
   localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
   localparam logic [1:0] CMD_CHOOSE   = 2'd1;
   localparam logic [1:0] CMD_COMPLETE = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_LOAD   = 2'd1;
   localparam logic [1:0] KIND_UNLOAD = 2'd2;
   localparam logic [1:0] KIND_RESULT = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_QUEUE_FULL = 2'd1;
   localparam logic [1:0] STATUS_CLEAN_FULL = 2'd2;

   typedef struct packed {
      logic [TAGW-1:0]   tag;
      logic [INSTW-1:0]  from_instance;
      logic [INSTW-1:0]  to_instance;
      logic [MODELW-1:0] from_model;
      logic [MODELW-1:0] to_model;
      logic              needs;
   } task_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [TAGW-1:0]   task_tag;
      logic [INSTW-1:0]  from_instance;
      logic [INSTW-1:0]  to_instance;
      logic [MODELW-1:0] from_model;
      logic [MODELW-1:0] to_model;
      logic              needs_resources;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [MODELW-1:0] model_index;
      logic [TAGW-1:0]   chosen_tag;
      logic              found;
      logic [1:0]        status;
      logic              last;
   } rsp_item_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ICHK, ST_IPOP, ST_IRD_A, ST_IWR_A, ST_IRD_B, ST_IWR_B,
      ST_SCAN, ST_SCAN_TO, ST_SCAN_EVAL, ST_SEL,
      ST_LF_RD, ST_LF_WR, ST_LT_RD, ST_LT_WR,
      ST_UCHK, ST_UPOP, ST_URD_A, ST_UWR_A, ST_URD_B, ST_UWR_B,
      ST_RESULT
   } state_type;

endpackage

/* src/rtp_req_if.sv */
// Request channel interface: valid, ready and one request item.
interface rtp_req_if;
   logic                 valid;
   logic                 ready;
   rtp_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/rtp_rsp_if.sv */
// Response channel interface: valid, ready and one response item.
interface rtp_rsp_if;
   logic                 valid;
   logic                 ready;
   rtp_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/rtp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rtp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/resource_aware_task_picker_core.sv */
// Task picker top level: task queue, use counts, cleanup fifos and sequencer.
// One item is handled at a time. Enqueue, complete and other commands finish in the
// cycle they are accepted and give one acknowledge. A choose walks a small sequencer
// around the instance and model count memories, which have one read and one write port
// each: it accepts the request, drains the instance cleanup fifo (an empty check before
// each pop, then a read and decrement of both instances of the entry), scans the queue
// oldest first (a task that needs no resources wins at once, one that does has its from
// and to counts read and is scored), retires the winner, loads the winner's models,
// checks for and runs one deferred unload pair, and gives the result. Stalls on the
// response side hold the sequencer. Counts start at zero through per-entry valid
// bits, so no clearing pass follows reset.
module resource_aware_task_picker_core (
   input  logic                 clock,
   input  logic                 reset,
   rtp_req_if.sink              req_ch,
   rtp_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [6:0]           csr_wdata
);
   import rtp_pkg::*;

   localparam int IAW = $clog2(NUM_INSTANCES);
   localparam int MAW = $clog2(NUM_MODELS);

   state_type            state_ff, state_in;
   logic [QCW-1:0]       qcount_ff, qcount_in;
   task_type             queue_ff [QUEUE_DEPTH];
   logic [NUM_INSTANCES-1:0] inst_valid_ff, inst_valid_in;
   logic [NUM_MODELS-1:0]    model_valid_ff, model_valid_in;
   logic [CIW-1:0]       ic_head_ff, ic_head_in, mc_head_ff, mc_head_in;
   logic [CCW-1:0]       ic_count_ff, ic_count_in, mc_count_ff, mc_count_in;
   logic [THRW-1:0]      thread_ff;
   logic [QCW-1:0]       idx_ff, idx_in;
   logic [QIW-1:0]       pick_ff, pick_in;
   logic [1:0]           best_ff, best_in;
   logic                 chosen_ff, chosen_in;
   task_type             task_ff, task_in;
   logic [INSTW-1:0]     pa_ff, pa_in, pb_ff, pb_in;
   logic                 fi_nz_ff, fi_nz_in, fm_zero_ff, fm_zero_in;
   logic [IAW-1:0]       inst_rq_ff;
   logic [MAW-1:0]       model_rq_ff;
   rsp_item_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // queue update controls
   logic                 q_write, q_remove;
   task_type             q_new, q_cur;

   // memory ports
   logic                 inst_we, model_we, ic_we, mc_we;
   logic [IAW-1:0]       inst_waddr, inst_raddr;
   logic [MAW-1:0]       model_waddr, model_raddr;
   logic [CNTW-1:0]      inst_wdata, model_wdata, inst_rdata, model_rdata;
   logic [CNTW-1:0]      inst_val, model_val;
   logic [CIW-1:0]       ic_waddr, mc_waddr;
   logic [2*INSTW-1:0]   ic_wdata, ic_rdata;
   logic [2*MODELW-1:0]  mc_wdata, mc_rdata;

   logic                 go, emit;
   rsp_item_type         emit_item;
   logic [1:0]           score;

   rtp_ram #(.WIDTH(CNTW), .DEPTH(NUM_INSTANCES)) u_inst_cnt (
      .clock(clock), .wr_en(inst_we), .wr_addr(inst_waddr), .wr_data(inst_wdata),
      .rd_addr(inst_raddr), .rd_data(inst_rdata));

   rtp_ram #(.WIDTH(CNTW), .DEPTH(NUM_MODELS)) u_model_cnt (
      .clock(clock), .wr_en(model_we), .wr_addr(model_waddr), .wr_data(model_wdata),
      .rd_addr(model_raddr), .rd_data(model_rdata));

   rtp_ram #(.WIDTH(2*INSTW), .DEPTH(CLEANUP_DEPTH)) u_ic_fifo (
      .clock(clock), .wr_en(ic_we), .wr_addr(ic_waddr), .wr_data(ic_wdata),
      .rd_addr(ic_head_ff), .rd_data(ic_rdata));

   rtp_ram #(.WIDTH(2*MODELW), .DEPTH(CLEANUP_DEPTH)) u_mc_fifo (
      .clock(clock), .wr_en(mc_we), .wr_addr(mc_waddr), .wr_data(mc_wdata),
      .rd_addr(mc_head_ff), .rd_data(mc_rdata));

   assign q_cur = queue_ff[idx_ff[QIW-1:0]];
   assign go    = !rsp_valid_ff || rsp_ch.ready;

   // counts never written read as zero
   assign inst_val  = inst_valid_ff[inst_rq_ff]   ? inst_rdata  : '0;
   assign model_val = model_valid_ff[model_rq_ff] ? model_rdata : '0;

   // read addresses follow the sequencer state; held otherwise so a stall keeps the data
   always_comb begin
      inst_raddr  = inst_rq_ff;
      model_raddr = model_rq_ff;
      case (state_ff)
         ST_SCAN: begin
            inst_raddr  = q_cur.from_instance;
            model_raddr = q_cur.from_model;
         end
         ST_SCAN_TO: begin
            inst_raddr  = q_cur.to_instance;
            model_raddr = q_cur.to_model;
         end
         ST_IRD_A: inst_raddr = pa_ff;
         ST_IRD_B: inst_raddr = pb_ff;
         ST_LF_RD: begin
            inst_raddr  = task_ff.from_instance;
            model_raddr = task_ff.from_model;
         end
         ST_LT_RD: begin
            inst_raddr  = task_ff.to_instance;
            model_raddr = task_ff.to_model;
         end
         ST_URD_A: model_raddr = pa_ff[MODELW-1:0];
         ST_URD_B: model_raddr = pb_ff[MODELW-1:0];
         default: ;
      endcase
   end

   assign score = {1'b0, fm_zero_ff} + {1'b0, (model_val == '0)};

   // sequencer: next state, memory writes and emitted items
   always_comb begin
      state_in       = state_ff;
      qcount_in      = qcount_ff;
      inst_valid_in  = inst_valid_ff;
      model_valid_in = model_valid_ff;
      ic_head_in     = ic_head_ff;
      ic_count_in    = ic_count_ff;
      mc_head_in     = mc_head_ff;
      mc_count_in    = mc_count_ff;
      idx_in         = idx_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      chosen_in      = chosen_ff;
      task_in        = task_ff;
      pa_in          = pa_ff;
      pb_in          = pb_ff;
      fi_nz_in       = fi_nz_ff;
      fm_zero_in     = fm_zero_ff;
      q_write        = 1'b0;
      q_remove       = 1'b0;
      q_new          = '0;
      inst_we        = 1'b0;
      inst_waddr     = '0;
      inst_wdata     = '0;
      model_we       = 1'b0;
      model_waddr    = '0;
      model_wdata    = '0;
      ic_we          = 1'b0;
      ic_waddr       = ic_head_ff + ic_count_ff[CIW-1:0];
      ic_wdata       = {req_ch.payload.from_instance, req_ch.payload.to_instance};
      mc_we          = 1'b0;
      mc_waddr       = mc_head_ff + mc_count_ff[CIW-1:0];
      mc_wdata       = {req_ch.payload.from_model, req_ch.payload.to_model};
      emit           = 1'b0;
      emit_item      = '0;
      req_ch.ready   = (state_ff == ST_IDLE) && go;

      if (go) begin
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  emit_item.kind   = KIND_ACK;
                  emit_item.last   = 1'b1;
                  case (req_ch.payload.command)
                     CMD_ENQUEUE: begin
                        emit = 1'b1;
                        if (qcount_ff >= QCW'(QUEUE_DEPTH)) begin
                           emit_item.status = STATUS_QUEUE_FULL;
                        end else begin
                           q_write = 1'b1;
                           q_new   = '{tag: req_ch.payload.task_tag,
                                       from_instance: req_ch.payload.from_instance,
                                       to_instance: req_ch.payload.to_instance,
                                       from_model: req_ch.payload.from_model,
                                       to_model: req_ch.payload.to_model,
                                       needs: req_ch.payload.needs_resources};
                           qcount_in = qcount_ff + 1'b1;
                        end
                     end
                     CMD_CHOOSE: begin
                        state_in = ST_ICHK;
                     end
                     CMD_COMPLETE: begin
                        emit = 1'b1;
                        if (req_ch.payload.needs_resources) begin
                           if (ic_count_ff >= CCW'(CLEANUP_DEPTH) ||
                               mc_count_ff >= CCW'(CLEANUP_DEPTH)) begin
                              emit_item.status = STATUS_CLEAN_FULL;
                           end else begin
                              ic_we       = 1'b1;
                              mc_we       = 1'b1;
                              ic_count_in = ic_count_ff + 1'b1;
                              mc_count_in = mc_count_ff + 1'b1;
                           end
                        end
                     end
                     default: emit = 1'b1;
                  endcase
               end
            end

            // drain the instance cleanup fifo
            ST_ICHK: begin
               if (ic_count_ff == '0) begin
                  idx_in    = '0;
                  best_in   = 2'd3;
                  chosen_in = 1'b0;
                  pick_in   = '0;
                  state_in  = ST_SCAN;
               end else begin
                  state_in = ST_IPOP;
               end
            end
            ST_IPOP: begin
               pa_in       = ic_rdata[2*INSTW-1:INSTW];
               pb_in       = ic_rdata[INSTW-1:0];
               ic_head_in  = ic_head_ff + 1'b1;
               ic_count_in = ic_count_ff - 1'b1;
               state_in    = ST_IRD_A;
            end
            ST_IRD_A: state_in = ST_IWR_A;
            ST_IWR_A: begin
               inst_we    = 1'b1;
               inst_waddr = pa_ff;
               inst_wdata = (inst_val != '0) ? inst_val - 1'b1 : '0;
               inst_valid_in[pa_ff] = 1'b1;
               state_in   = ST_IRD_B;
            end
            ST_IRD_B: state_in = ST_IWR_B;
            ST_IWR_B: begin
               inst_we    = 1'b1;
               inst_waddr = pb_ff;
               inst_wdata = (inst_val != '0) ? inst_val - 1'b1 : '0;
               inst_valid_in[pb_ff] = 1'b1;
               state_in   = ST_ICHK;
            end

            // scan the queue, oldest first
            ST_SCAN: begin
               if (idx_ff >= qcount_ff) begin
                  state_in = ST_SEL;
               end else if (!q_cur.needs) begin
                  chosen_in = 1'b1;
                  pick_in   = idx_ff[QIW-1:0];
                  task_in   = q_cur;
                  state_in  = ST_SEL;
               end else begin
                  state_in = ST_SCAN_TO;
               end
            end
            ST_SCAN_TO: begin
               fi_nz_in   = (inst_val != '0);
               fm_zero_in = (model_val == '0);
               state_in   = ST_SCAN_EVAL;
            end
            ST_SCAN_EVAL: begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN;
               if (!fi_nz_ff && inst_val == '0 && score < best_ff) begin
                  best_in   = score;
                  pick_in   = idx_ff[QIW-1:0];
                  chosen_in = 1'b1;
                  task_in   = q_cur;
                  if (score == 2'd0) begin
                     state_in = ST_SEL;
                  end
               end
            end

            // retire the winner
            ST_SEL: begin
               if (chosen_ff) begin
                  q_remove  = 1'b1;
                  qcount_in = qcount_ff - 1'b1;
                  state_in  = task_ff.needs ? ST_LF_RD : ST_UCHK;
               end else begin
                  state_in = ST_UCHK;
               end
            end
            ST_LF_RD: state_in = ST_LF_WR;
            ST_LF_WR: begin
               emit                  = (model_val == '0);
               emit_item.kind        = KIND_LOAD;
               emit_item.model_index = task_ff.from_model;
               model_we    = 1'b1;
               model_waddr = task_ff.from_model;
               model_wdata = (model_val != COUNT_MAX) ? model_val + 1'b1 : model_val;
               model_valid_in[task_ff.from_model] = 1'b1;
               inst_we     = 1'b1;
               inst_waddr  = task_ff.from_instance;
               inst_wdata  = (inst_val != COUNT_MAX) ? inst_val + 1'b1 : inst_val;
               inst_valid_in[task_ff.from_instance] = 1'b1;
               state_in    = ST_LT_RD;
            end
            ST_LT_RD: state_in = ST_LT_WR;
            ST_LT_WR: begin
               emit                  = (model_val == '0);
               emit_item.kind        = KIND_LOAD;
               emit_item.model_index = task_ff.to_model;
               model_we    = 1'b1;
               model_waddr = task_ff.to_model;
               model_wdata = (model_val != COUNT_MAX) ? model_val + 1'b1 : model_val;
               model_valid_in[task_ff.to_model] = 1'b1;
               inst_we     = 1'b1;
               inst_waddr  = task_ff.to_instance;
               inst_wdata  = (inst_val != COUNT_MAX) ? inst_val + 1'b1 : inst_val;
               inst_valid_in[task_ff.to_instance] = 1'b1;
               state_in    = ST_UCHK;
            end

            // one deferred model unload pair
            ST_UCHK: begin
               if ((chosen_ff || THRW'(qcount_ff) < thread_ff) &&
                   THRW'(mc_count_ff) > thread_ff) begin
                  state_in = ST_UPOP;
               end else begin
                  state_in = ST_RESULT;
               end
            end
            ST_UPOP: begin
               pa_in       = INSTW'(mc_rdata[2*MODELW-1:MODELW]);
               pb_in       = INSTW'(mc_rdata[MODELW-1:0]);
               mc_head_in  = mc_head_ff + 1'b1;
               mc_count_in = mc_count_ff - 1'b1;
               state_in    = ST_URD_A;
            end
            ST_URD_A: state_in = ST_UWR_A;
            ST_UWR_A: begin
               emit                  = (model_val == CNTW'(1));
               emit_item.kind        = KIND_UNLOAD;
               emit_item.model_index = pa_ff[MODELW-1:0];
               model_we    = 1'b1;
               model_waddr = pa_ff[MODELW-1:0];
               model_wdata = (model_val != '0) ? model_val - 1'b1 : '0;
               model_valid_in[pa_ff[MODELW-1:0]] = 1'b1;
               state_in    = ST_URD_B;
            end
            ST_URD_B: state_in = ST_UWR_B;
            ST_UWR_B: begin
               emit                  = (model_val == CNTW'(1));
               emit_item.kind        = KIND_UNLOAD;
               emit_item.model_index = pb_ff[MODELW-1:0];
               model_we    = 1'b1;
               model_waddr = pb_ff[MODELW-1:0];
               model_wdata = (model_val != '0) ? model_val - 1'b1 : '0;
               model_valid_in[pb_ff[MODELW-1:0]] = 1'b1;
               state_in    = ST_RESULT;
            end

            ST_RESULT: begin
               emit                 = 1'b1;
               emit_item.kind       = KIND_RESULT;
               emit_item.chosen_tag = chosen_ff ? task_ff.tag : '0;
               emit_item.found      = chosen_ff;
               emit_item.last       = 1'b1;
               state_in             = ST_IDLE;
            end
            default: state_in = ST_IDLE;
         endcase
      end

      // output register
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_item;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         qcount_ff      <= '0;
         inst_valid_ff  <= '0;
         model_valid_ff <= '0;
         ic_head_ff     <= '0;
         ic_count_ff    <= '0;
         mc_head_ff     <= '0;
         mc_count_ff    <= '0;
         thread_ff      <= THREAD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         qcount_ff      <= qcount_in;
         inst_valid_ff  <= inst_valid_in;
         model_valid_ff <= model_valid_in;
         ic_head_ff     <= ic_head_in;
         ic_count_ff    <= ic_count_in;
         mc_head_ff     <= mc_head_in;
         mc_count_ff    <= mc_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            thread_ff <= csr_wdata;
         end
      end
   end

   // scan and payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      chosen_ff   <= chosen_in;
      task_ff     <= task_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      fi_nz_ff    <= fi_nz_in;
      fm_zero_ff  <= fm_zero_in;
      inst_rq_ff  <= inst_raddr;
      model_rq_ff <= model_raddr;
      rsp_ff      <= rsp_in;
   end

   // task queue: append at the fill count, close the gap on removal
   always_ff @(posedge clock) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         if (q_remove && QIW'(j) >= pick_ff && j < QUEUE_DEPTH - 1) begin
            queue_ff[j] <= queue_ff[j + 1];
         end else if (q_write && qcount_ff == QCW'(j)) begin
            queue_ff[j] <= q_new;
         end
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // checks
   a_qcount_bound: assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= QCW'(QUEUE_DEPTH)) else $error("queue fill count out of range");

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      ic_count_ff <= CCW'(CLEANUP_DEPTH) && mc_count_ff <= CCW'(CLEANUP_DEPTH))
      else $error("cleanup fifo count out of range");

   a_result_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_RESULT |-> rsp_ff.last)
      else $error("choice result not marked last");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ch.ready) else $error("ready while busy");

endmodule
